@@ src/pfb_pkg.sv @@
// Shared types and codes for the page framebuffer draw and flush block.
// No dependencies; used by pfb_ctrl, pfb_dp and the top level.
package pfb_pkg;

  localparam logic [2:0] REQ_FILL    = 3'd0;
  localparam logic [2:0] REQ_PIXEL   = 3'd1;
  localparam logic [2:0] REQ_RECT    = 3'd2;
  localparam logic [2:0] REQ_OUTLINE = 3'd3;
  localparam logic [2:0] REQ_HLINE   = 3'd4;
  localparam logic [2:0] REQ_FLUSH   = 3'd5;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_WIN  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  // Segment shapes handed to the pixel walker.
  localparam logic [2:0] SEG_PIX   = 3'd0;
  localparam logic [2:0] SEG_RECT  = 3'd1;
  localparam logic [2:0] SEG_HLINE = 3'd2;
  localparam logic [2:0] SEG_TOP   = 3'd3;
  localparam logic [2:0] SEG_BOT   = 3'd4;
  localparam logic [2:0] SEG_LEFT  = 3'd5;
  localparam logic [2:0] SEG_RIGHT = 3'd6;

  localparam int HALF_BYTES = 64;
  localparam int HALF_BITS  = HALF_BYTES * 8;

  localparam logic [7:0] WIN_COL_CMD  = 8'h21;
  localparam logic [7:0] WIN_COL_LO   = 8'h00;
  localparam logic [7:0] WIN_COL_HI   = 8'h7F;
  localparam logic [7:0] WIN_PAGE_CMD = 8'h22;
  localparam logic [7:0] BYTE_ON      = 8'hFF;
  localparam logic [7:0] BYTE_OFF     = 8'h00;

  typedef struct packed {
    logic       accept;
    logic       sweep_on;
    logic       sweep_lit;
    logic       seg_load;
    logic [2:0] seg_sel;
    logic       pix_rd;
    logic       pix_wr;
    logic       gat_init;
    logic       gat_rd;
    logic       out_load;
    logic [1:0] out_kind;
    logic       page_next;
  } pfb_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       wh_zero;
    logic       seg_empty;
    logic       seg_last;
    logic       sweep_last;
    logic       col_last;
    logic       slot_free;
    logic       reject;
    logic       cnt_zero;
    logic       data_last;
  } pfb_stat_t;

endpackage

@@ src/pfb_dp.sv @@
// Datapath: frame memory, pixel walker, page gather buffer and result register.
// Depends on pfb_pkg; driven by commands from pfb_ctrl.
module pfb_dp #(
  parameter int COLUMNS   = 128,
  parameter int NUM_PAGES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfb_pkg::pfb_cmd_t cmd_i,
  output pfb_pkg::pfb_stat_t stat_o,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_pos_x,
  input  logic [7:0]        in_pos_y,
  input  logic [7:0]        in_rect_w,
  input  logic [7:0]        in_rect_h,
  input  logic              in_pixel_on,
  input  logic [7:0]        in_first_page,
  input  logic [7:0]        in_page_total,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic              out_last,
  output logic [2:0]        out_page_index,
  output logic              out_half_index,
  output logic [63:0]       out_data_0,
  output logic [63:0]       out_data_1,
  output logic [63:0]       out_data_2,
  output logic [63:0]       out_data_3,
  output logic [63:0]       out_data_4,
  output logic [63:0]       out_data_5,
  output logic [63:0]       out_data_6,
  output logic [63:0]       out_data_7
);
  import pfb_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = NUM_PAGES * (2 ** CW);
  localparam int ROWS  = NUM_PAGES * 8;

  logic [7:0] mem [DEPTH];

  // Latched request.
  logic [2:0] req_r;
  logic [7:0] x_r, y_r, w_r, h_r, start_r, count_r;
  logic       lit_r;

  // Pixel walker.
  logic [7:0] ox_r, oy_r, ww_r, hh_r, i_r, j_r;
  logic [AW-1:0] paddr_r;
  logic [2:0]    pbit_r;
  logic          pin_r;

  // Sweep and gather.
  logic [AW-1:0] cnt_r;
  logic [5:0]    col_r;
  logic [2:0]    page_r;
  logic          half_r;
  logic [7:0]    pleft_r;
  logic          cap_r, capz_r;
  logic [HALF_BITS-1:0] gbuf_r;
  logic [7:0]    rd_data_r;

  logic out_valid_r;
  logic [1:0] kind_r;
  logic last_r, half_out_r;
  logic [2:0] page_out_r;
  logic [HALF_BITS-1:0] data_r;

  logic [7:0] px, py, gcol, wbyte, mask, end_pg, cnt_clamp;
  logic       pin_c, gz_c;
  logic [AW-1:0] paddr_c, gaddr, waddr, raddr;
  logic       we, re;
  logic [7:0] wdata;

  logic [7:0] seg_ox, seg_oy, seg_ww, seg_hh;
  logic       last_c, half_c;
  logic [2:0] page_c;
  logic [HALF_BITS-1:0] data_c;

  assign px     = ox_r + j_r;
  assign py     = oy_r + i_r;
  assign pin_c  = ({1'b0, px} < 9'(COLUMNS)) && ({1'b0, py} < 9'(ROWS));
  assign paddr_c = {py[PW+2:3], px[CW-1:0]};
  assign gcol   = {1'b0, half_r, col_r};
  assign gz_c   = ({1'b0, gcol} >= 9'(COLUMNS));
  assign gaddr  = {page_r[PW-1:0], gcol[CW-1:0]};
  assign mask   = 8'(1) << pbit_r;
  assign wbyte  = lit_r ? (rd_data_r | mask) : (rd_data_r & ~mask);
  assign end_pg = start_r + count_r - 8'd1;
  assign cnt_clamp = (({1'b0, in_first_page} + {1'b0, in_page_total}) > 9'(NUM_PAGES))
                   ? 8'(NUM_PAGES) - in_first_page : in_page_total;

  // The reset clear always writes dark bytes; a fill uses the request's color.
  assign we    = cmd_i.sweep_on || (cmd_i.pix_wr && pin_r);
  assign waddr = cmd_i.sweep_on ? cnt_r : paddr_r;
  assign wdata = cmd_i.sweep_on ? ((cmd_i.sweep_lit && lit_r) ? BYTE_ON : BYTE_OFF) : wbyte;
  assign re    = (cmd_i.pix_rd && pin_c) || cmd_i.gat_rd;
  assign raddr = cmd_i.pix_rd ? paddr_c : gaddr;

  always_comb begin
    seg_ox = x_r;
    seg_oy = y_r;
    seg_ww = w_r;
    seg_hh = h_r;
    case (cmd_i.seg_sel)
      SEG_PIX: begin
        seg_ww = 8'd1;
        seg_hh = 8'd1;
      end
      SEG_HLINE, SEG_TOP: seg_hh = 8'd1;
      SEG_BOT: begin
        seg_oy = y_r + h_r - 8'd1;
        seg_hh = 8'd1;
      end
      SEG_LEFT: seg_ww = 8'd1;
      SEG_RIGHT: begin
        seg_ox = x_r + w_r - 8'd1;
        seg_ww = 8'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    last_c = 1'b1;
    page_c = 3'd0;
    half_c = 1'b0;
    data_c = '0;
    case (cmd_i.out_kind)
      KIND_WIN: begin
        last_c = (count_r == 8'd0);
        data_c[63:0] = {16'd0, end_pg, start_r, WIN_PAGE_CMD, WIN_COL_HI,
                        WIN_COL_LO, WIN_COL_CMD};
      end
      KIND_DATA: begin
        last_c = stat_o.data_last;
        page_c = page_r;
        half_c = half_r;
        data_c = gbuf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      req_r   <= in_req_type;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      w_r     <= in_rect_w;
      h_r     <= in_rect_h;
      lit_r   <= in_pixel_on;
      start_r <= in_first_page;
      count_r <= cnt_clamp;
    end
    if (cmd_i.seg_load) begin
      i_r  <= 8'd0;
      j_r  <= 8'd0;
      ox_r <= seg_ox;
      oy_r <= seg_oy;
      ww_r <= seg_ww;
      hh_r <= seg_hh;
    end
    if (cmd_i.pix_rd) begin
      paddr_r <= paddr_c;
      pbit_r  <= py[2:0];
      pin_r   <= pin_c;
    end
    // A new outline edge restarts the walk, so its load wins over the step.
    if (cmd_i.pix_wr && !cmd_i.seg_load) begin
      if (j_r == ww_r - 8'd1) begin
        j_r <= 8'd0;
        i_r <= i_r + 8'd1;
      end else begin
        j_r <= j_r + 8'd1;
      end
    end
    if (cmd_i.gat_init) begin
      page_r  <= start_r[2:0];
      half_r  <= 1'b0;
      pleft_r <= count_r;
    end
    if (cmd_i.page_next) begin
      half_r <= ~half_r;
      if (half_r) begin
        page_r  <= page_r + 3'd1;
        pleft_r <= pleft_r - 8'd1;
      end
    end
    capz_r <= gz_c;
    if (cap_r) begin
      gbuf_r <= {(capz_r ? 8'd0 : rd_data_r), gbuf_r[HALF_BITS-1:8]};
    end
    if (cmd_i.out_load) begin
      kind_r     <= cmd_i.out_kind;
      last_r     <= last_c;
      page_out_r <= page_c;
      half_out_r <= half_c;
      data_r     <= data_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      col_r       <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.sweep_on) begin
        cnt_r <= stat_o.sweep_last ? '0 : cnt_r + AW'(1);
      end
      if (cmd_i.gat_rd) begin
        col_r <= col_r + 6'd1;
      end
      cap_r <= cmd_i.gat_rd;
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.req_type   = req_r;
    stat_o.wh_zero    = (w_r == 8'd0) || (h_r == 8'd0);
    stat_o.seg_empty  = (ww_r == 8'd0) || (hh_r == 8'd0);
    stat_o.seg_last   = (j_r == ww_r - 8'd1) && (i_r == hh_r - 8'd1);
    stat_o.sweep_last = (cnt_r == AW'(DEPTH - 1));
    stat_o.col_last   = (col_r == 6'd63);
    stat_o.slot_free  = !out_valid_r || out_ready;
    stat_o.reject     = ({1'b0, start_r} >= 9'(NUM_PAGES));
    stat_o.cnt_zero   = (count_r == 8'd0);
    stat_o.data_last  = (pleft_r == 8'd1) && half_r;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_last       = last_r;
  assign out_page_index = page_out_r;
  assign out_half_index = half_out_r;
  assign out_data_0     = data_r[63:0];
  assign out_data_1     = data_r[127:64];
  assign out_data_2     = data_r[191:128];
  assign out_data_3     = data_r[255:192];
  assign out_data_4     = data_r[319:256];
  assign out_data_5     = data_r[383:320];
  assign out_data_6     = data_r[447:384];
  assign out_data_7     = data_r[511:448];

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> stat_o.slot_free) else $error("result overwritten");
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pix_wr |-> $past(cmd_i.pix_rd)) else $error("pixel write without read");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_i.sweep_on && cmd_i.pix_wr)) else $error("two memory writers");
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.out_load && cmd_i.out_kind == KIND_DATA) |-> ({5'd0, page_r} < 8'(NUM_PAGES)))
    else $error("data page out of range");

endmodule

@@ src/pfb_ctrl.sv @@
// Controller state machine for the page framebuffer block.
// Depends on pfb_pkg; issues commands to pfb_dp and reads its status.
module pfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfb_pkg::pfb_stat_t stat_i,
  output pfb_pkg::pfb_cmd_t  cmd_o
);
  import pfb_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_SWEEP  = 4'd3;
  localparam logic [3:0] S_SEGCHK = 4'd4;
  localparam logic [3:0] S_PRD    = 4'd5;
  localparam logic [3:0] S_PWR    = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;
  localparam logic [3:0] S_REJ    = 4'd8;
  localparam logic [3:0] S_WIN    = 4'd9;
  localparam logic [3:0] S_GRD    = 4'd10;
  localparam logic [3:0] S_GWT    = 4'd11;
  localparam logic [3:0] S_GOUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] seg_r, seg_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    cmd_o     = '0;
    case (state_r)
      S_CLR: begin
        cmd_o.sweep_on = 1'b1;
        if (stat_i.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (stat_i.req_type)
          REQ_FILL: state_nxt = S_SWEEP;
          REQ_PIXEL, REQ_RECT, REQ_HLINE: begin
            seg_nxt = (stat_i.req_type == REQ_PIXEL) ? SEG_PIX :
                      (stat_i.req_type == REQ_RECT) ? SEG_RECT : SEG_HLINE;
            cmd_o.seg_load = 1'b1;
            cmd_o.seg_sel  = seg_nxt;
            state_nxt      = S_SEGCHK;
          end
          REQ_OUTLINE: begin
            if (!stat_i.wh_zero) begin
              seg_nxt        = SEG_TOP;
              cmd_o.seg_load = 1'b1;
              cmd_o.seg_sel  = SEG_TOP;
              state_nxt      = S_SEGCHK;
            end
          end
          REQ_FLUSH: state_nxt = stat_i.reject ? S_REJ : S_WIN;
          default: ;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep_on  = 1'b1;
        cmd_o.sweep_lit = 1'b1;
        if (stat_i.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SEGCHK: begin
        state_nxt = stat_i.seg_empty ? S_DONE : S_PRD;
      end
      S_PRD: begin
        cmd_o.pix_rd = 1'b1;
        state_nxt    = S_PWR;
      end
      S_PWR: begin
        cmd_o.pix_wr = 1'b1;
        state_nxt    = S_PRD;
        if (stat_i.seg_last) begin
          // The outline walks its top, bottom, left and right edges in turn.
          if (seg_r == SEG_TOP || seg_r == SEG_BOT || seg_r == SEG_LEFT) begin
            seg_nxt        = seg_r + 3'd1;
            cmd_o.seg_load = 1'b1;
            cmd_o.seg_sel  = seg_nxt;
            state_nxt      = S_SEGCHK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE, S_REJ: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = (state_r == S_REJ) ? KIND_REJ : KIND_DONE;
          state_nxt      = S_IDLE;
        end
      end
      S_WIN: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_WIN;
          cmd_o.gat_init = 1'b1;
          state_nxt      = stat_i.cnt_zero ? S_IDLE : S_GRD;
        end
      end
      S_GRD: begin
        cmd_o.gat_rd = 1'b1;
        if (stat_i.col_last) begin
          state_nxt = S_GWT;
        end
      end
      S_GWT: state_nxt = S_GOUT;
      S_GOUT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_kind  = KIND_DATA;
          cmd_o.page_next = 1'b1;
          state_nxt       = stat_i.data_last ? S_IDLE : S_GRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      seg_r   <= SEG_PIX;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.accept |=> (state_r == S_DISP)) else $error("accept did not dispatch");
  a_walk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_o.gat_rd && (cmd_o.pix_rd || cmd_o.sweep_on))) else $error("port conflict");
  a_gwt_after_grd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GWT) |-> $past(cmd_o.gat_rd)) else $error("gather drain out of order");

endmodule

@@ src/page_framebuffer_draw_flush.sv @@
// Page-organized 1-bpp framebuffer with drawing and flush requests.
// Depends on pfb_pkg, pfb_ctrl and pfb_dp.
//
// Requests come in on in_valid/in_ready, one word at a time; the block works
// on one request until its last result word has been loaded into the result
// register that drives out_valid/out_ready. Every request ends with a result
// word marked out_last. Work per request, after acceptance:
//   drawing: a memory read, then a write, for each pixel visited, plus
//   dispatch and result; each pixel is a read-modify-write of its byte in
//   the frame memory.
//   fill all: a write of every memory byte, NUM_PAGES * 2**clog2(COLUMNS),
//   plus dispatch and result.
//   flush: the window word, then for each half page one memory read per byte
//   into the gather buffer.
// The result register decouples the two sides: a stalled receiver holds the
// current word while the next half page is gathered, and the block simply
// waits when it has another word ready. After reset the block clears all
// NUM_PAGES * 2**clog2(COLUMNS) bytes of the frame memory, one byte per cycle,
// with in_ready low.
module page_framebuffer_draw_flush #(
  parameter int COLUMNS   = 128,
  parameter int NUM_PAGES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [7:0]  in_rect_w,
  input  logic [7:0]  in_rect_h,
  input  logic        in_pixel_on,
  input  logic [7:0]  in_first_page,
  input  logic [7:0]  in_page_total,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [2:0]  out_page_index,
  output logic        out_half_index,
  output logic [63:0] out_data_0,
  output logic [63:0] out_data_1,
  output logic [63:0] out_data_2,
  output logic [63:0] out_data_3,
  output logic [63:0] out_data_4,
  output logic [63:0] out_data_5,
  output logic [63:0] out_data_6,
  output logic [63:0] out_data_7
);
  import pfb_pkg::*;

  pfb_cmd_t  cmd;
  pfb_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  pfb_dp #(
    .COLUMNS   (COLUMNS),
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_req_type    (in_req_type),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_pixel_on    (in_pixel_on),
    .in_first_page  (in_first_page),
    .in_page_total  (in_page_total),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_last       (out_last),
    .out_page_index (out_page_index),
    .out_half_index (out_half_index),
    .out_data_0     (out_data_0),
    .out_data_1     (out_data_1),
    .out_data_2     (out_data_2),
    .out_data_3     (out_data_3),
    .out_data_4     (out_data_4),
    .out_data_5     (out_data_5),
    .out_data_6     (out_data_6),
    .out_data_7     (out_data_7)
  );

endmodule
